### rtl/stepper_step_pulse_generator_core_macros.svh
// concurrent assertion helpers, clocked on clk_i and held off during reset
`ifndef STEPPER_STEP_PULSE_GENERATOR_CORE_MACROS_SVH
`define STEPPER_STEP_PULSE_GENERATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define STPG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define STPG_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define STPG_ASSERT(lbl, prop, msg)
`define STPG_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

### rtl/stpg_pkg.sv
`default_nettype none

package stpg_pkg;

  localparam int unsigned PERIOD_BITS_DEF     = 16;
  localparam int unsigned STEP_COUNT_BITS_DEF = 32;
  localparam int unsigned PW_W                = 16;
  localparam int unsigned STEPS_IN_W          = 32;
  localparam int unsigned PERIOD_IN_W         = 16;
  localparam int unsigned IN_TDATA_W          = 56;
  localparam int unsigned IN_TUSER_W          = 3;
  localparam int unsigned OUT_TDATA_W         = 8;
  localparam logic [PW_W-1:0] PW_RESET        = 16'd2;

  typedef enum logic [2:0] {
    REQ_TICK  = 3'd0,
    REQ_START = 3'd1,
    REQ_STOP  = 3'd2,
    REQ_SLEEP = 3'd3,
    REQ_WAKE  = 3'd4,
    REQ_DIR   = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SLEEPING = 2'd1,
    ST_FAULT    = 2'd2,
    ST_BUSY     = 2'd3
  } status_e;

endpackage

`default_nettype wire

### rtl/stepper_step_pulse_generator_core.sv
// channel    dir  tdata (lsb first)                                      tuser
// s_axis     in   move_steps[31:0] step_period[47:32] direction_req[48]  req_type[2:0]
// m_axis     out  status[1:0] step_out[2] dir_out[3] awake_out[4]        -
//                 move_running[5] move_done[6]
// cfg        in   pulse_width[15:0] on cfg_we_i                          -
//
// one beat per cycle: each request updates the state and lands in the result register
// on the edge it is accepted, result visible the next cycle
// the result register drains while the next beat is taken: s_axis_tready is low only
// when a result is held and m_axis_tready is low
// async active-low reset clears the move state, wakes the driver, direction low,
// pulse width 2
`default_nettype none

`include "stepper_step_pulse_generator_core_macros.svh"

module stepper_step_pulse_generator_core
  import stpg_pkg::*;
#(
  parameter int unsigned PERIOD_BITS     = PERIOD_BITS_DEF,
  parameter int unsigned STEP_COUNT_BITS = STEP_COUNT_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [PW_W-1:0]        cfg_wdata_i,
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  // move_steps, step_period, direction_req, zero pad
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // req_type
  input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // status, step_out, dir_out, awake_out, move_running, move_done, zero pad
  output      logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam logic [31:0] PERIOD_MAX = 32'hFFFF_FFFF >> (32 - PERIOD_BITS);
  localparam logic [31:0] STEPS_MAX  = 32'hFFFF_FFFF >> (32 - STEP_COUNT_BITS);

  logic [PW_W-1:0]            pw_q;
  logic                       active_q, active_d;
  logic [STEP_COUNT_BITS-1:0] steps_left_q, steps_left_d;
  logic [PERIOD_BITS-1:0]     period_len_q, period_len_d;
  logic [PERIOD_BITS-1:0]     phase_q, phase_d;
  logic                       asleep_q, asleep_d;
  logic                       dir_q, dir_d;
  logic                       out_valid_q;
  logic [OUT_TDATA_W-1:0]     out_data_q;

  logic                       in_acc;
  logic [STEPS_IN_W-1:0]      steps_in;
  logic [PERIOD_IN_W-1:0]     period_in;
  logic [31:0]                steps_sat, period_sat;
  logic [PERIOD_BITS-1:0]     phase_inc;
  status_e                    status_d;
  logic                       step_lvl, done_d;
  logic [OUT_TDATA_W-1:0]     out_data_d;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign steps_in      = s_axis_tdata[STEPS_IN_W-1:0];
  assign period_in     = s_axis_tdata[STEPS_IN_W +: PERIOD_IN_W];
  assign steps_sat     = (steps_in > STEPS_MAX) ? STEPS_MAX : steps_in;
  assign period_sat    = (32'(period_in) > PERIOD_MAX) ? PERIOD_MAX : 32'(period_in);
  assign phase_inc     = phase_q + PERIOD_BITS'(1);

  always_comb begin
    active_d     = active_q;
    steps_left_d = steps_left_q;
    period_len_d = period_len_q;
    phase_d      = phase_q;
    asleep_d     = asleep_q;
    dir_d        = dir_q;
    status_d     = ST_OK;
    done_d       = 1'b0;
    case (s_axis_tuser)
      REQ_TICK: begin
        if (active_q) begin
          if (phase_inc >= period_len_q) begin
            phase_d = '0;
            if (steps_left_q > STEP_COUNT_BITS'(1)) begin
              steps_left_d = steps_left_q - STEP_COUNT_BITS'(1);
            end else begin
              active_d     = 1'b0;
              steps_left_d = '0;
              period_len_d = '0;
              done_d       = 1'b1;
            end
          end else begin
            phase_d = phase_inc;
          end
        end
      end
      REQ_START: begin
        if (asleep_q) begin
          status_d = ST_SLEEPING;
        end else if (steps_sat == 32'd0 || period_sat <= 32'(pw_q)) begin
          status_d = ST_FAULT;
        end else if (active_q) begin
          status_d = ST_BUSY;
        end else begin
          steps_left_d = steps_sat[STEP_COUNT_BITS-1:0];
          period_len_d = period_sat[PERIOD_BITS-1:0];
          phase_d      = '0;
          active_d     = 1'b1;
        end
      end
      REQ_STOP, REQ_SLEEP: begin
        active_d     = 1'b0;
        steps_left_d = '0;
        period_len_d = '0;
        phase_d      = '0;
        if (s_axis_tuser == REQ_SLEEP) begin
          asleep_d = 1'b1;
        end
      end
      REQ_WAKE: begin
        asleep_d = 1'b0;
      end
      REQ_DIR: begin
        dir_d = s_axis_tdata[STEPS_IN_W + PERIOD_IN_W];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (s_axis_tuser == REQ_TICK) begin
      step_lvl = active_q && (32'(phase_q) < 32'(pw_q));
    end else begin
      step_lvl = active_d && (32'(phase_d) < 32'(pw_q));
    end
    out_data_d = {1'b0, done_d, active_d, !asleep_d, dir_d, step_lvl, status_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_q         <= PW_RESET;
      active_q     <= 1'b0;
      steps_left_q <= '0;
      period_len_q <= '0;
      phase_q      <= '0;
      asleep_q     <= 1'b0;
      dir_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pw_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        active_q     <= active_d;
        steps_left_q <= steps_left_d;
        period_len_q <= period_len_d;
        phase_q      <= phase_d;
        asleep_q     <= asleep_d;
        dir_q        <= dir_d;
        out_valid_q  <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `STPG_ASSERT(a_phase_in_period, !active_q || (phase_q < period_len_q), "phase past period")
  `STPG_ASSERT(a_idle_cleared, active_q || (steps_left_q == '0 && phase_q == '0), "idle state dirty")
  `STPG_ASSERT_NEXT(a_done_ends_move, in_acc && done_d, !active_q, "move still running after done")
  `STPG_ASSERT_NEXT(a_result_held, in_acc, out_valid_q && out_data_q == $past(out_data_d), "result lost")

endmodule

`default_nettype wire

### verif/tb.sv
`default_nettype none

module tb;
  import stpg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REQ_RSVD_A = 3'd6;
  localparam logic [2:0] REQ_RSVD_B = 3'd7;
  localparam int unsigned PHASE_ITEMS = 190;

  typedef struct {
    status_e status;
    logic    step;
    logic    dir;
    logic    awake;
    logic    running;
    logic    done;
  } pins_t;

  class pulse_gen_scoreboard;
    logic [PW_W-1:0]        pulse_width;
    logic                   active;
    logic                   asleep;
    logic                   dir_state;
    logic [STEPS_IN_W-1:0]  steps_left;
    logic [PERIOD_IN_W-1:0] period_len;
    logic [PERIOD_IN_W-1:0] phase;
    pins_t                  expected_pins[$];
    int unsigned            errors;
    int unsigned            checked;
    int unsigned            finished_moves;
    int unsigned            refused_starts;

    function new();
      pulse_width    = PW_RESET;
      asleep         = 1'b0;
      dir_state      = 1'b0;
      errors         = 0;
      checked        = 0;
      finished_moves = 0;
      refused_starts = 0;
      end_move();
    endfunction

    function void end_move();
      active     = 1'b0;
      steps_left = '0;
      period_len = '0;
      phase      = '0;
    endfunction

    function void set_pulse_width(logic [PW_W-1:0] value);
      pulse_width = value;
    endfunction

    // advance the pin state by one request and return the pin levels it leaves
    function pins_t apply_request(logic [2:0] req, logic [STEPS_IN_W-1:0] steps,
                                  logic [PERIOD_IN_W-1:0] period, logic dir);
      pins_t r;
      r.status = ST_OK;
      r.done   = 1'b0;
      if (req == REQ_TICK) begin
        r.step = active && (phase < pulse_width);
        if (active) begin
          phase = phase + 1'b1;
          if (phase >= period_len) begin
            phase = '0;
            if (steps_left > 1) begin
              steps_left = steps_left - 1'b1;
            end else begin
              end_move();
              r.done = 1'b1;
              finished_moves++;
            end
          end
        end
      end else begin
        case (req)
          REQ_START: begin
            if (asleep) begin
              r.status = ST_SLEEPING;
            end else if (steps == 0 || period <= pulse_width) begin
              r.status = ST_FAULT;
            end else if (active) begin
              r.status = ST_BUSY;
            end else begin
              steps_left = steps;
              period_len = period;
              phase      = '0;
              active     = 1'b1;
            end
            if (r.status != ST_OK) refused_starts++;
          end
          REQ_STOP: end_move();
          REQ_SLEEP: begin
            end_move();
            asleep = 1'b1;
          end
          REQ_WAKE: asleep = 1'b0;
          REQ_DIR: dir_state = dir;
          default: ;
        endcase
        r.step = active && (phase < pulse_width);
      end
      r.dir     = dir_state;
      r.awake   = !asleep;
      r.running = active;
      return r;
    endfunction

    function void note_request(logic [2:0] req, logic [STEPS_IN_W-1:0] steps,
                               logic [PERIOD_IN_W-1:0] period, logic dir);
      expected_pins.push_back(apply_request(req, steps, period, dir));
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] beat);
      pins_t want;
      if (expected_pins.size() == 0) begin
        $error("result beat 0x%02h with no request outstanding", beat);
        errors++;
        return;
      end
      want = expected_pins.pop_front();
      checked++;
      compare_field("status", 32'(want.status), 32'(beat[1:0]));
      compare_field("step_out", 32'(want.step), 32'(beat[2]));
      compare_field("dir_out", 32'(want.dir), 32'(beat[3]));
      compare_field("awake_out", 32'(want.awake), 32'(beat[4]));
      compare_field("move_running", 32'(want.running), 32'(beat[5]));
      compare_field("move_done", 32'(want.done), 32'(beat[6]));
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [PW_W-1:0]        cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  pulse_gen_scoreboard book;
  int unsigned         send_idle_pct = 0;
  int unsigned         recv_idle_pct = 0;
  int unsigned         requests_sent = 0;

  stepper_step_pulse_generator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) book.check_result(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_request(input logic [2:0] req, input logic [31:0] steps = '0,
                              input logic [15:0] period = '0, input logic dir = 1'b0);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {7'd0, dir, period, steps};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    book.note_request(req, steps, period, dir);
    if (req < REQ_RSVD_A) requests_sent++;
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (book.expected_pins.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_pulse_width(input logic [PW_W-1:0] value);
    wait_for_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    book.set_pulse_width(value);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_noise();
    logic [2:0]  req;
    logic [31:0] steps;
    logic [15:0] period;
    req    = 3'($urandom_range(7));
    steps  = ($urandom_range(3) == 0) ? $urandom_range(2) : $urandom;
    period = 16'(($urandom_range(1) == 0) ? $urandom_range(8) : $urandom);
    send_request(req, steps, period, 1'($urandom_range(1)));
  endtask

  // wake if asleep, maybe stop, maybe turn, start a short move, then tick it through with rare interruptions
  task automatic run_move_episode();
    int unsigned n_steps;
    int unsigned per;
    int unsigned n_ticks;
    if (book.asleep) send_request(REQ_WAKE, $urandom, 16'($urandom), 1'($urandom_range(1)));
    if (book.active && $urandom_range(1) == 0) send_request(REQ_STOP, $urandom, 16'($urandom), 1'b0);
    if ($urandom_range(3) == 0) send_request(REQ_DIR, $urandom, 16'($urandom), 1'($urandom_range(1)));
    n_steps = $urandom_range(1, 4);
    per = book.pulse_width + $urandom_range(1, 4);
    if (per > 65535) per = 65535;
    send_request(REQ_START, 32'(n_steps), 16'(per), 1'($urandom_range(1)));
    n_ticks = n_steps * per + $urandom_range(2);
    repeat (n_ticks) begin
      if ($urandom_range(39) == 0) send_noise();
      else send_request(REQ_TICK, $urandom, 16'($urandom), 1'($urandom_range(1)));
    end
  endtask

  task automatic run_random_phase(input int unsigned send_pct, input int unsigned recv_pct);
    int unsigned target;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    target = requests_sent + PHASE_ITEMS;
    while (requests_sent < target) begin
      if ($urandom_range(4) == 0) send_noise();
      else run_move_episode();
      if ($urandom_range(49) == 0) wait_for_results();
    end
  endtask

  initial begin
    int unsigned waited;
    book = new();
    send_idle_pct = 21;
    recv_idle_pct = 72;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // refusals and idle behavior at reset pulse width
    send_request(REQ_TICK);
    send_request(REQ_START, 32'd0, 16'd100);
    send_request(REQ_START, 32'd1, 16'd2);
    send_request(REQ_SLEEP);
    send_request(REQ_START, 32'd0, 16'd0);
    send_request(REQ_TICK);
    send_request(REQ_WAKE);
    send_request(REQ_WAKE);
    send_request(REQ_STOP);
    send_request(REQ_DIR, '1, '1, 1'b1);
    // short move with busy and fault tried mid-move
    send_request(REQ_START, 32'd2, 16'd3);
    send_request(REQ_START, 32'd1, 16'd5);
    send_request(REQ_START, 32'd0, 16'd5);
    repeat (7) send_request(REQ_TICK);
    // widest counts, then stop
    send_request(REQ_START, 32'hFFFF_FFFF, 16'hFFFF);
    repeat (3) send_request(REQ_TICK, '1, '1, 1'b1);
    send_request(REQ_STOP);
    // sleep in the middle of a move
    send_request(REQ_START, 32'd1, 16'd3);
    send_request(REQ_TICK);
    send_request(REQ_SLEEP);
    send_request(REQ_TICK);
    send_request(REQ_WAKE);
    send_request(REQ_DIR, '0, '0, 1'b0);
    send_request(REQ_RSVD_A, '1, '1, 1'b1);
    send_request(REQ_RSVD_B, '1, '1, 1'b1);

    // narrowest pulse, then widen it while the move runs
    write_pulse_width(16'd1);
    send_request(REQ_START, 32'd3, 16'd2);
    repeat (2) send_request(REQ_TICK);
    write_pulse_width(16'd4);
    repeat (5) send_request(REQ_TICK);

    write_pulse_width(16'd3);
    run_random_phase(21, 72);

    // widest pulse: nothing can start; one below it, a start at the longest period runs
    write_pulse_width(16'hFFFF);
    send_request(REQ_STOP);
    send_request(REQ_START, 32'd1, 16'hFFFF);
    send_request(REQ_TICK);
    write_pulse_width(16'hFFFE);
    send_request(REQ_START, 32'd1, 16'hFFFF);
    repeat (4) send_request(REQ_TICK);
    send_request(REQ_STOP);

    write_pulse_width(16'($urandom_range(1, 6)));
    run_random_phase(72, 21);
    write_pulse_width(PW_RESET);
    run_random_phase(0, 0);

    wait_for_results();
    waited = 0;
    while (book.expected_pins.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    if (book.expected_pins.size() != 0) begin
      $error("%0d results never arrived", book.expected_pins.size());
      book.errors++;
    end
    $display("%0d requests sent, %0d result beats checked", requests_sent, book.checked);
    $display("%0d moves ran to the last step, %0d starts refused",
             book.finished_moves, book.refused_starts);
    if (book.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
+incdir+rtl
rtl/stpg_pkg.sv
rtl/stepper_step_pulse_generator_core.sv
verif/tb.sv
